// ----- rtl/core/pmgas_pkg.sv -----
package pmgas_pkg;

    localparam int MAX_GRID     = 256;
    localparam int MAX_PATCH    = 32;
    localparam int MAX_MERGE    = 8;
    localparam int MAX_CHANNELS = 16;
    localparam int FRAME_LIMIT  = 16;
    localparam int IMAGE_LIMIT  = 4096;

    localparam int RECIP_SHIFT = 10;

    typedef enum logic [2:0] {
        REG_CHANNELS,
        REG_FRAMES,
        REG_IMAGE_HEIGHT,
        REG_IMAGE_WIDTH,
        REG_PATCH_SIZE,
        REG_MERGE_SIZE,
        REG_GRID_ROWS,
        REG_GRID_COLS
    } reg_index_t;

    typedef struct packed {
        logic [4:0]  channels;
        logic [4:0]  frames;
        logic [12:0] height;
        logic [12:0] width;
        logic [5:0]  patch;
        logic [3:0]  merge;
        logic [8:0]  rows;
        logic [8:0]  cols;
    } cfg_t;

    typedef struct packed {
        logic [7:0] gy;
        logic [7:0] gx;
        logic [3:0] c;
        logic [3:0] t;
        logic [4:0] py;
        logic [4:0] px;
        logic       last;
    } pos_t;

    typedef struct packed {
        logic [12:0] y;
        logic [12:0] x;
        logic [7:0]  ct;
        logic [8:0]  cn;
        logic [10:0] pp;
        logic [8:0]  qy;
        logic [8:0]  qx;
        logic [8:0]  qc;
        logic [7:0]  gy;
        logic [7:0]  gx;
        logic [4:0]  py;
        logic [4:0]  px;
        logic        last;
    } s1_t;

    typedef struct packed {
        logic        oob;
        logic [20:0] src_a;
        logic [12:0] feat_a;
        logic [18:0] fc;
        logic [7:0]  br;
        logic [2:0]  mr;
        logic [7:0]  bc;
        logic [2:0]  mc;
        logic [8:0]  bw;
        logic [12:0] x;
        logic [4:0]  px;
        logic        last;
    } s2_t;

    typedef struct packed {
        logic [31:0] src;
        logic [17:0] feat;
        logic [16:0] token_a;
        logic [5:0]  mrmc;
        logic [6:0]  mm;
        logic [18:0] fc;
        logic        oob;
        logic        last;
    } s3_t;

    typedef struct packed {
        logic [22:0] token;
        logic [18:0] fc;
        logic [17:0] feat;
        logic [31:0] src;
        logic        oob;
        logic        last;
    } s4_t;

    typedef struct packed {
        logic [31:0] src;
        logic [33:0] dst;
        logic        oob;
        logic        last;
    } s5_t;

    typedef struct packed {
        logic [8:0] q;
        logic [2:0] r;
    } divq_t;

    function automatic logic [12:0] clamp13(logic [12:0] v, logic [12:0] hi);
        logic [12:0] res;
        if (v == 13'd0) begin
            res = 13'd1;
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

    function automatic logic [10:0] recip(logic [3:0] m);
        logic [10:0] res;
        unique case (m)
            4'd2:    res = 11'd512;
            4'd3:    res = 11'd341;
            4'd4:    res = 11'd256;
            4'd5:    res = 11'd204;
            4'd6:    res = 11'd170;
            4'd7:    res = 11'd146;
            4'd8:    res = 11'd128;
            default: res = 11'd1024;
        endcase
        return res;
    endfunction

    // The estimate is the true quotient or one less.
    function automatic logic [8:0] div_est(logic [8:0] n, logic [3:0] m);
        logic [19:0] prod;
        prod = 20'(n) * 20'(recip(m));
        return prod[RECIP_SHIFT+8:RECIP_SHIFT];
    endfunction

    function automatic divq_t div_fix(logic [8:0] n, logic [8:0] q, logic [3:0] m);
        logic [12:0] prod;
        logic [9:0]  r;
        divq_t       res;
        prod = 13'(q) * 13'(m);
        r    = 10'(n) - prod[9:0];
        if (r >= 10'(m)) begin
            res.q = q + 9'd1;
            r     = r - 10'(m);
        end else begin
            res.q = q;
        end
        res.r = r[2:0];
        return res;
    endfunction

endpackage

// ----- rtl/core/pmgas_front.sv -----
module pmgas_front
    import pmgas_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic in_valid,
    output logic in_stall,
    input  logic restart,
    input  logic q_full,
    output logic push,
    output pos_t push_data
);

    logic [7:0] gy_reg, gy_next;
    logic [7:0] gx_reg, gx_next;
    logic [3:0] c_reg, c_next;
    logic [3:0] t_reg, t_next;
    logic [4:0] py_reg, py_next;
    logic [4:0] px_reg, px_next;

    logic [7:0] gy, gx;
    logic [3:0] c, t;
    logic [4:0] py, px;
    logic       px_w, py_w, t_w, c_w, gx_w, gy_w;
    logic       cy0, cy1, cy2, cy3, cy4;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        gy = restart ? 8'd0 : gy_reg;
        gx = restart ? 8'd0 : gx_reg;
        c  = restart ? 4'd0 : c_reg;
        t  = restart ? 4'd0 : t_reg;
        py = restart ? 5'd0 : py_reg;
        px = restart ? 5'd0 : px_reg;

        px_w = (6'(px) + 6'd1) >= cfg.patch;
        py_w = (6'(py) + 6'd1) >= cfg.patch;
        t_w  = (5'(t) + 5'd1) >= cfg.frames;
        c_w  = (5'(c) + 5'd1) >= cfg.channels;
        gx_w = (9'(gx) + 9'd1) >= cfg.cols;
        gy_w = (9'(gy) + 9'd1) >= cfg.rows;

        cy0 = px_w;
        cy1 = cy0 && py_w;
        cy2 = cy1 && t_w;
        cy3 = cy2 && c_w;
        cy4 = cy3 && gx_w;

        px_next = px_w ? 5'd0 : px + 5'd1;
        py_next = !cy0 ? py : (py_w ? 5'd0 : py + 5'd1);
        t_next  = !cy1 ? t : (t_w ? 4'd0 : t + 4'd1);
        c_next  = !cy2 ? c : (c_w ? 4'd0 : c + 4'd1);
        gx_next = !cy3 ? gx : (gx_w ? 8'd0 : gx + 8'd1);
        gy_next = !cy4 ? gy : (gy_w ? 8'd0 : gy + 8'd1);

        push_data.gy   = gy;
        push_data.gx   = gx;
        push_data.c    = c;
        push_data.t    = t;
        push_data.py   = py;
        push_data.px   = px;
        push_data.last = cy4 && gy_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gy_reg <= '0;
            gx_reg <= '0;
            c_reg  <= '0;
            t_reg  <= '0;
            py_reg <= '0;
            px_reg <= '0;
        end
        else if (push)
        begin
            gy_reg <= gy_next;
            gx_reg <= gx_next;
            c_reg  <= c_next;
            t_reg  <= t_next;
            py_reg <= py_next;
            px_reg <= px_next;
        end
    end

endmodule

// ----- rtl/core/pmgas_queue.sv -----
module pmgas_queue
    import pmgas_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  pos_t push_data,
    output logic full,
    input  logic pop,
    output logic empty,
    output pos_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pos_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = count_reg == CNT_W'(DEPTH);
    assign empty = count_reg == '0;
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/core/pmgas_back.sv -----
module pmgas_back
    import pmgas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        q_empty,
    input  pos_t        head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] source_index,
    output logic [33:0] dest_index,
    output logic        last,
    output logic        out_of_bounds
);

    logic [4:0] valid_reg;
    logic       adv;

    s1_t s1_reg, s1_next;
    s2_t s2_reg, s2_next;
    s3_t s3_reg, s3_next;
    s4_t s4_reg, s4_next;
    s5_t s5_reg, s5_next;

    assign adv = !(valid_reg[4] && out_stall);
    assign pop = adv && !q_empty;

    always_comb
    begin
        s1_next.y    = 13'(head.gy) * 13'(cfg.patch) + 13'(head.py);
        s1_next.x    = 13'(head.gx) * 13'(cfg.patch) + 13'(head.px);
        s1_next.ct   = 8'(head.c) * 8'(cfg.frames) + 8'(head.t);
        s1_next.cn   = 9'(cfg.channels) * 9'(cfg.frames);
        s1_next.pp   = 11'(cfg.patch) * 11'(cfg.patch);
        s1_next.qy   = div_est(9'(head.gy), cfg.merge);
        s1_next.qx   = div_est(9'(head.gx), cfg.merge);
        s1_next.qc   = div_est(cfg.cols, cfg.merge);
        s1_next.gy   = head.gy;
        s1_next.gx   = head.gx;
        s1_next.py   = head.py;
        s1_next.px   = head.px;
        s1_next.last = head.last;
    end

    always_comb
    begin
        divq_t dy;
        divq_t dx;
        divq_t dc;
        dy = div_fix(9'(s1_reg.gy), s1_reg.qy, cfg.merge);
        dx = div_fix(9'(s1_reg.gx), s1_reg.qx, cfg.merge);
        dc = div_fix(cfg.cols, s1_reg.qc, cfg.merge);

        s2_next.oob    = (s1_reg.y >= cfg.height) || (s1_reg.x >= cfg.width);
        s2_next.src_a  = 21'(s1_reg.ct) * 21'(cfg.height) + 21'(s1_reg.y);
        s2_next.feat_a = 13'(s1_reg.ct) * 13'(cfg.patch) + 13'(s1_reg.py);
        s2_next.fc     = 19'(s1_reg.cn) * 19'(s1_reg.pp);
        s2_next.br     = dy.q[7:0];
        s2_next.mr     = dy.r;
        s2_next.bc     = dx.q[7:0];
        s2_next.mc     = dx.r;
        s2_next.bw     = dc.q;
        s2_next.x      = s1_reg.x;
        s2_next.px     = s1_reg.px;
        s2_next.last   = s1_reg.last;
    end

    always_comb
    begin
        logic [33:0] src_prod;
        src_prod = 34'(s2_reg.src_a) * 34'(cfg.width);

        s3_next.src     = s2_reg.oob ? 32'd0 : src_prod[31:0] + 32'(s2_reg.x);
        s3_next.feat    = 18'(s2_reg.feat_a) * 18'(cfg.patch) + 18'(s2_reg.px);
        s3_next.token_a = 17'(s2_reg.br) * 17'(s2_reg.bw) + 17'(s2_reg.bc);
        s3_next.mrmc    = 6'(s2_reg.mr) * 6'(cfg.merge) + 6'(s2_reg.mc);
        s3_next.mm      = 7'(cfg.merge) * 7'(cfg.merge);
        s3_next.fc      = s2_reg.fc;
        s3_next.oob     = s2_reg.oob;
        s3_next.last    = s2_reg.last;
    end

    always_comb
    begin
        s4_next.token = 23'(s3_reg.token_a) * 23'(s3_reg.mm) + 23'(s3_reg.mrmc);
        s4_next.fc    = s3_reg.fc;
        s4_next.feat  = s3_reg.feat;
        s4_next.src   = s3_reg.src;
        s4_next.oob   = s3_reg.oob;
        s4_next.last  = s3_reg.last;
    end

    always_comb
    begin
        logic [41:0] dsum;
        dsum = 42'(s4_reg.token) * 42'(s4_reg.fc) + 42'(s4_reg.feat);

        s5_next.src  = s4_reg.src;
        s5_next.dst  = dsum[33:0];
        s5_next.oob  = s4_reg.oob;
        s5_next.last = s4_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[3:0], !q_empty};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
        end
    end

    assign out_valid     = valid_reg[4];
    assign source_index  = s5_reg.src;
    assign dest_index    = s5_reg.dst;
    assign last          = s5_reg.last;
    assign out_of_bounds = s5_reg.oob;

endmodule

// ----- rtl/core/patch_merge_gather_address_sequencer_unit.sv -----
// Patchify gather address sequencer with spatial merge. Every accepted item steps six nested
// counters (grid row, grid column, channel, frame, patch row, patch column) and yields one
// result with the source element index, the token-major destination index, a last flag on
// the final element and an out-of-bounds flag for pixels outside the image; a restart item
// starts again from the first element. The block sustains one item per cycle while the
// output is not stalled. The counter front end feeds a small queue, and a five-stage
// multiply pipeline behind it produces the addresses. The queue lets the input keep flowing
// for up to QUEUE_DEPTH items while the output is stalled. Configuration registers take
// effect at once and should be written only while no item is in flight.
module patch_merge_gather_address_sequencer_unit
    import pmgas_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        restart,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] source_index,
    output logic [33:0] dest_index,
    output logic        last,
    output logic        out_of_bounds
);

    logic [4:0]  channels_reg;
    logic [4:0]  frames_reg;
    logic [12:0] height_reg;
    logic [12:0] width_reg;
    logic [5:0]  patch_reg;
    logic [3:0]  merge_reg;
    logic [8:0]  rows_reg;
    logic [8:0]  cols_reg;

    cfg_t cfg;
    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    pos_t push_data;
    pos_t head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channels_reg <= 5'd1;
            frames_reg   <= 5'd1;
            height_reg   <= 13'd1;
            width_reg    <= 13'd1;
            patch_reg    <= 6'd1;
            merge_reg    <= 4'd1;
            rows_reg     <= 9'd1;
            cols_reg     <= 9'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CHANNELS:     channels_reg <= cfg_data[4:0];
                REG_FRAMES:       frames_reg   <= cfg_data[4:0];
                REG_IMAGE_HEIGHT: height_reg   <= cfg_data;
                REG_IMAGE_WIDTH:  width_reg    <= cfg_data;
                REG_PATCH_SIZE:   patch_reg    <= cfg_data[5:0];
                REG_MERGE_SIZE:   merge_reg    <= cfg_data[3:0];
                REG_GRID_ROWS:    rows_reg     <= cfg_data[8:0];
                REG_GRID_COLS:    cols_reg     <= cfg_data[8:0];
                default:          ;
            endcase
        end
    end

    // Zero reads as one and anything above the supported bound reads as that bound.
    always_comb
    begin
        cfg.channels = 5'(clamp13(13'(channels_reg), 13'(MAX_CHANNELS)));
        cfg.frames   = 5'(clamp13(13'(frames_reg), 13'(FRAME_LIMIT)));
        cfg.height   = clamp13(height_reg, 13'(IMAGE_LIMIT));
        cfg.width    = clamp13(width_reg, 13'(IMAGE_LIMIT));
        cfg.patch    = 6'(clamp13(13'(patch_reg), 13'(MAX_PATCH)));
        cfg.merge    = 4'(clamp13(13'(merge_reg), 13'(MAX_MERGE)));
        cfg.rows     = 9'(clamp13(13'(rows_reg), 13'(MAX_GRID)));
        cfg.cols     = 9'(clamp13(13'(cols_reg), 13'(MAX_GRID)));
    end

    pmgas_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .restart   (restart),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    pmgas_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .empty     (q_empty),
        .head      (head)
    );

    pmgas_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .q_empty       (q_empty),
        .head          (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .source_index  (source_index),
        .dest_index    (dest_index),
        .last          (last),
        .out_of_bounds (out_of_bounds)
    );

endmodule
